FILE: rtl/ict_pkg.sv
// ----------------------------------------------------------------------------
// Interval cluster table package
// Types, register codes and constants shared by the cell chain and the top
// level.
// ----------------------------------------------------------------------------
package ict_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;

   localparam int VALUE_W    = 12;
   localparam int FACTOR_W   = 9;
   localparam int FRAC_W     = 8;
   localparam int PROD_W     = FACTOR_W + VALUE_W;
   localparam int SLOT_MAX_W = 8;
   localparam int USED_MAX_W = 9;

   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [VALUE_W-1:0]  COUNT_MAX         = 12'hFFF;
   localparam logic [FACTOR_W-1:0] LOW_FACTOR_RESET  = 9'd230;
   localparam logic [FACTOR_W-1:0] HIGH_FACTOR_RESET = 9'd282;
   localparam logic [VALUE_W-1:0]  MAX_GAP_RESET     = 12'd100;

   localparam logic [REG_IDX_W-1:0] REG_LOW_FACTOR  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIGH_FACTOR = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MAX_GAP     = 2'd2;

   typedef enum logic [1:0] {
      OUTCOME_COUNTED = 2'd0,
      OUTCOME_NEW     = 2'd1,
      OUTCOME_DROPPED = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [FACTOR_W-1:0] low_factor;
      logic [FACTOR_W-1:0] high_factor;
      logic [VALUE_W-1:0]  max_gap;
   } cfg_type;

   // What travels down the chain: a request still searching, or its result.
   typedef struct packed {
      logic                  valid;
      logic                  done;
      outcome_type           outcome;
      logic [SLOT_MAX_W-1:0] slot;
      logic [VALUE_W-1:0]    value;
      logic [VALUE_W-1:0]    span_low;
      logic [VALUE_W-1:0]    span_high;
      logic [VALUE_W-1:0]    hits;
   } token_type;

   typedef struct packed {
      outcome_type           outcome;
      logic [SLOT_MAX_W-1:0] slot;
      logic [VALUE_W-1:0]    span_low;
      logic [VALUE_W-1:0]    span_high;
      logic [VALUE_W-1:0]    hits;
      logic [USED_MAX_W-1:0] used;
   } result_type;

endpackage

FILE: rtl/interval_cluster_table.sv
// ----------------------------------------------------------------------------
// Interval cluster table
// Sorts a stream of values into a table of intervals with hit counts.
// ----------------------------------------------------------------------------
// Each request walks a chain of TABLE_DEPTH cells, one cell per clock, and
// the first interval that fits it takes it, else it opens a new one or is
// dropped when the table is full; the result is registered before the rsp
// channel. The table takes no new request while one is still in the chain.
// The next request is accepted in the cycle its predecessor leaves the chain,
// provided the output register is empty then. Otherwise the input stays
// stalled past that cycle, and for as long as the newer result waits in a
// spare holding stage behind a stalled output.
module interval_cluster_table #(
   parameter int TABLE_DEPTH = ict_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ict_pkg::VALUE_W-1:0]        req_sample_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_outcome,
   output logic [$clog2(TABLE_DEPTH)-1:0]     rsp_slot,
   output logic [ict_pkg::VALUE_W-1:0]        rsp_span_low,
   output logic [ict_pkg::VALUE_W-1:0]        rsp_span_high,
   output logic [ict_pkg::VALUE_W-1:0]        rsp_hits,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   rsp_used_slots,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ict_pkg::ADDR_W-1:0]         paddr,
   input  logic [ict_pkg::DATA_W-1:0]         pwdata,
   output logic [ict_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   ict_pkg::cfg_type    cfg_ff, cfg_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                busy_ff, busy_in;
   ict_pkg::token_type  inj_ff, inj_in;
   logic                park_v_ff, park_v_in;
   ict_pkg::result_type park_ff, park_in;
   logic                out_v_ff, out_v_in;
   ict_pkg::result_type out_ff, out_in;

   ict_pkg::token_type  chain [TABLE_DEPTH+1];
   ict_pkg::token_type  tail;
   ict_pkg::result_type tail_res;
   logic                accept;
   logic                out_free;
   logic                cfg_write;
   logic [ict_pkg::REG_IDX_W-1:0] reg_idx;

   assign chain[0] = inj_ff;
   assign tail     = chain[TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ict_cell #(
         .TABLE_DEPTH(TABLE_DEPTH),
         .CELL_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .fill    (fill_ff),
         .up_tok  (chain[i]),
         .down_tok(chain[i+1])
      );
   end

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ict_pkg::REG_IDX_W+1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_idx)
            ict_pkg::REG_LOW_FACTOR: begin
               cfg_in.low_factor = pwdata[ict_pkg::FACTOR_W-1:0];
            end
            ict_pkg::REG_HIGH_FACTOR: begin
               cfg_in.high_factor = pwdata[ict_pkg::FACTOR_W-1:0];
            end
            ict_pkg::REG_MAX_GAP: begin
               cfg_in.max_gap = pwdata[ict_pkg::VALUE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ict_pkg::REG_LOW_FACTOR:  prdata = ict_pkg::DATA_W'(cfg_ff.low_factor);
         ict_pkg::REG_HIGH_FACTOR: prdata = ict_pkg::DATA_W'(cfg_ff.high_factor);
         ict_pkg::REG_MAX_GAP:     prdata = ict_pkg::DATA_W'(cfg_ff.max_gap);
         default:                  prdata = '0;
      endcase
   end

   assign req_stall = park_v_ff || (busy_ff && (!tail.valid || out_v_ff));
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_v_ff || !rsp_stall;

   always_comb begin
      tail_res.outcome   = ict_pkg::OUTCOME_DROPPED;
      tail_res.slot      = '0;
      tail_res.span_low  = '0;
      tail_res.span_high = '0;
      tail_res.hits      = '0;
      tail_res.used      = ict_pkg::USED_MAX_W'(fill_ff);
      if (tail.done) begin
         tail_res.outcome   = tail.outcome;
         tail_res.slot      = tail.slot;
         tail_res.span_low  = tail.span_low;
         tail_res.span_high = tail.span_high;
         tail_res.hits      = tail.hits;
         if (tail.outcome == ict_pkg::OUTCOME_NEW) begin
            tail_res.used = ict_pkg::USED_MAX_W'(fill_ff) + ict_pkg::USED_MAX_W'(1);
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (tail.valid && tail.done && (tail.outcome == ict_pkg::OUTCOME_NEW)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
      inj_in       = '0;
      inj_in.valid = accept;
      inj_in.value = req_sample_value;
   end

   always_comb begin
      park_v_in = park_v_ff;
      park_in   = park_ff;
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      if (park_v_ff) begin
         if (out_free) begin
            out_v_in  = 1'b1;
            out_in    = park_ff;
            park_v_in = 1'b0;
         end
      end else if (tail.valid) begin
         if (out_free) begin
            out_v_in = 1'b1;
            out_in   = tail_res;
         end else begin
            park_v_in = 1'b1;
            park_in   = tail_res;
         end
      end else if (out_free) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_factor  <= ict_pkg::LOW_FACTOR_RESET;
         cfg_ff.high_factor <= ict_pkg::HIGH_FACTOR_RESET;
         cfg_ff.max_gap     <= ict_pkg::MAX_GAP_RESET;
         fill_ff            <= '0;
         busy_ff            <= 1'b0;
         park_v_ff          <= 1'b0;
         out_v_ff           <= 1'b0;
      end else begin
         cfg_ff    <= cfg_in;
         fill_ff   <= fill_in;
         busy_ff   <= busy_in;
         park_v_ff <= park_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      park_ff <= park_in;
      out_ff  <= out_in;
      if (reset) begin
         inj_ff <= '0;
      end else begin
         inj_ff <= inj_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_outcome    = out_ff.outcome;
   assign rsp_slot       = out_ff.slot[SLOT_W-1:0];
   assign rsp_span_low   = out_ff.span_low;
   assign rsp_span_high  = out_ff.span_high;
   assign rsp_hits       = out_ff.hits;
   assign rsp_used_slots = out_ff.used[FILL_W-1:0];

endmodule

FILE: rtl/ict_cell.sv
// ----------------------------------------------------------------------------
// Interval cluster table cell
// Holds one interval and tests the passing request against it, counting it
// here, widening the interval, or opening the interval when this is the
// first free entry.
// ----------------------------------------------------------------------------
module ict_cell #(
   parameter int TABLE_DEPTH = ict_pkg::TABLE_DEPTH_DEFAULT,
   parameter int CELL_INDEX  = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ict_pkg::cfg_type                 cfg,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] fill,
   input  ict_pkg::token_type               up_tok,
   output ict_pkg::token_type               down_tok
);

   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [FILL_W-1:0] CellPos = FILL_W'(CELL_INDEX);
   localparam logic [ict_pkg::SLOT_MAX_W-1:0] CellSlot = ict_pkg::SLOT_MAX_W'(CELL_INDEX);

   logic [ict_pkg::VALUE_W-1:0] low_ff, low_in;
   logic [ict_pkg::VALUE_W-1:0] high_ff, high_in;
   logic [ict_pkg::VALUE_W-1:0] count_ff, count_in;
   ict_pkg::token_type          tok_ff, tok_in;

   logic [ict_pkg::PROD_W-1:0] scaled;
   logic [ict_pkg::PROD_W-1:0] low_bound;
   logic [ict_pkg::PROD_W-1:0] high_bound;
   logic                       fits;

   assign scaled     = ict_pkg::PROD_W'({up_tok.value, {ict_pkg::FRAC_W{1'b0}}});
   assign low_bound  = ict_pkg::PROD_W'(cfg.low_factor) * ict_pkg::PROD_W'(low_ff);
   assign high_bound = ict_pkg::PROD_W'(cfg.high_factor) * ict_pkg::PROD_W'(high_ff);
   assign fits       = (scaled > low_bound) && (scaled <= high_bound);

   always_comb begin
      logic                        take;
      logic [ict_pkg::VALUE_W-1:0] new_low;
      logic [ict_pkg::VALUE_W-1:0] new_high;
      logic [ict_pkg::VALUE_W-1:0] new_count;
      take      = 1'b0;
      new_low   = low_ff;
      new_high  = high_ff;
      new_count = (count_ff < ict_pkg::COUNT_MAX) ? count_ff + 1'b1 : count_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      count_in  = count_ff;
      tok_in    = up_tok;
      if (up_tok.valid && !up_tok.done) begin
         if (CellPos < fill) begin
            if (fits) begin
               if (up_tok.value <= low_ff) begin
                  if ((high_ff - up_tok.value) <= cfg.max_gap) begin
                     new_low = up_tok.value;
                     take    = 1'b1;
                  end
               end else if (up_tok.value > high_ff) begin
                  if ((up_tok.value - low_ff) <= cfg.max_gap) begin
                     new_high = up_tok.value;
                     take     = 1'b1;
                  end
               end else begin
                  take = 1'b1;
               end
            end
            if (take) begin
               low_in           = new_low;
               high_in          = new_high;
               count_in         = new_count;
               tok_in.done      = 1'b1;
               tok_in.outcome   = ict_pkg::OUTCOME_COUNTED;
               tok_in.slot      = CellSlot;
               tok_in.span_low  = new_low;
               tok_in.span_high = new_high;
               tok_in.hits      = new_count;
            end
         end else if (CellPos == fill) begin
            low_in           = up_tok.value;
            high_in          = up_tok.value;
            count_in         = ict_pkg::VALUE_W'(1);
            tok_in.done      = 1'b1;
            tok_in.outcome   = ict_pkg::OUTCOME_NEW;
            tok_in.slot      = CellSlot;
            tok_in.span_low  = up_tok.value;
            tok_in.span_high = up_tok.value;
            tok_in.hits      = ict_pkg::VALUE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      count_ff <= count_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

FILE: bench/tb_interval_cluster_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval cluster table testbench
// Drives requests through the table and checks every result against an
// in-bench model of the interval search. A scripted opening covers the value
// extremes, boundary moves, span limits and register extremes. Random phases
// follow under several register settings, with values aimed mostly around
// the live intervals, random idling on both channels and one long output
// hold-off. A closing phase without idling repeats one value on the table
// and fills the table until requests are dropped. Each register is written
// through the APB port and read back.
// ----------------------------------------------------------------------------
module tb_interval_cluster_table;

   localparam int TABLE_DEPTH      = ict_pkg::TABLE_DEPTH_DEFAULT;
   localparam int SLOT_W           = $clog2(TABLE_DEPTH);
   localparam int USED_W           = $clog2(TABLE_DEPTH + 1);
   localparam int VALUE_MAX        = 2**ict_pkg::VALUE_W - 1;
   localparam int PIPE_LATENCY     = TABLE_DEPTH + 1;
   localparam int DRAIN_CYCLES     = 2 * PIPE_LATENCY;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_PHASES    = 5;
   localparam int PHASE_REQUESTS   = 80;
   localparam int REPEAT_REQUESTS  = 60;
   localparam int FILL_REQUESTS    = 20;
   localparam int CYCLE_LIMIT      = 1000000;

   localparam logic [ict_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CFG  = 1'b1
   } row_kind_type;

   typedef struct packed {
      ict_pkg::outcome_type        outcome;
      logic [SLOT_W-1:0]           slot;
      logic [ict_pkg::VALUE_W-1:0] span_low;
      logic [ict_pkg::VALUE_W-1:0] span_high;
      logic [ict_pkg::VALUE_W-1:0] hits;
      logic [USED_W-1:0]           used_slots;
   } cluster_result_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [ict_pkg::REG_IDX_W-1:0] reg_idx;
      logic [ict_pkg::DATA_W-1:0]    data;
      logic                          typed;
      cluster_result_type            known;
   } script_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [ict_pkg::VALUE_W-1:0]   req_sample_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_outcome;
   logic [SLOT_W-1:0]             rsp_slot;
   logic [ict_pkg::VALUE_W-1:0]   rsp_span_low;
   logic [ict_pkg::VALUE_W-1:0]   rsp_span_high;
   logic [ict_pkg::VALUE_W-1:0]   rsp_hits;
   logic [USED_W-1:0]             rsp_used_slots;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [ict_pkg::ADDR_W-1:0]    paddr;
   logic [ict_pkg::DATA_W-1:0]    pwdata;
   logic [ict_pkg::DATA_W-1:0]    prdata;
   logic                          pready;

   logic [ict_pkg::FACTOR_W-1:0]  lo_factor_now;
   logic [ict_pkg::FACTOR_W-1:0]  hi_factor_now;
   logic [ict_pkg::VALUE_W-1:0]   gap_now;
   logic [ict_pkg::VALUE_W-1:0]   span_lo_copy   [TABLE_DEPTH];
   logic [ict_pkg::VALUE_W-1:0]   span_hi_copy   [TABLE_DEPTH];
   logic [ict_pkg::VALUE_W-1:0]   hit_count_copy [TABLE_DEPTH];
   logic [USED_W-1:0]             slots_in_use;

   cluster_result_type    expected_q [$];
   script_row_type        script [$];

   bit                    idling;
   bit                    long_hold;
   int unsigned           error_count;
   int unsigned           sent_count;
   int unsigned           write_count;
   int unsigned           counted_seen;
   int unsigned           new_seen;
   int unsigned           dropped_seen;
   int unsigned           peak_hits;
   int unsigned           cycle_count;

   interval_cluster_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_outcome      (rsp_outcome),
      .rsp_slot         (rsp_slot),
      .rsp_span_low     (rsp_span_low),
      .rsp_span_high    (rsp_span_high),
      .rsp_hits         (rsp_hits),
      .rsp_used_slots   (rsp_used_slots),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // First-fit search over the live intervals, updating the bench's own table.
   function automatic cluster_result_type cluster_value(input logic [ict_pkg::VALUE_W-1:0] v);
      cluster_result_type r;
      int unsigned        scaled;
      int unsigned        lf;
      int unsigned        hf;
      int unsigned        lo;
      int unsigned        hi;
      bit                 taken;
      r      = '0;
      taken  = 1'b0;
      scaled = v;
      scaled = scaled << ict_pkg::FRAC_W;
      lf     = lo_factor_now;
      hf     = hi_factor_now;
      for (int j = 0; j < int'(slots_in_use) && !taken; j++) begin
         lo = span_lo_copy[j];
         hi = span_hi_copy[j];
         if (scaled > lf * lo && scaled <= hf * hi) begin
            if (v <= lo) begin
               if (hi - v <= gap_now) begin
                  lo    = v;
                  taken = 1'b1;
               end
            end else if (v > hi) begin
               if (v - lo <= gap_now) begin
                  hi    = v;
                  taken = 1'b1;
               end
            end else begin
               taken = 1'b1;
            end
            if (taken) begin
               if (hit_count_copy[j] != ict_pkg::COUNT_MAX) begin
                  hit_count_copy[j] = hit_count_copy[j] + 1'b1;
               end
               span_lo_copy[j] = ict_pkg::VALUE_W'(lo);
               span_hi_copy[j] = ict_pkg::VALUE_W'(hi);
               r.outcome   = ict_pkg::OUTCOME_COUNTED;
               r.slot      = SLOT_W'(j);
               r.span_low  = span_lo_copy[j];
               r.span_high = span_hi_copy[j];
               r.hits      = hit_count_copy[j];
            end
         end
      end
      if (!taken) begin
         if (slots_in_use < TABLE_DEPTH) begin
            span_lo_copy[slots_in_use]   = v;
            span_hi_copy[slots_in_use]   = v;
            hit_count_copy[slots_in_use] = ict_pkg::VALUE_W'(1);
            r.outcome   = ict_pkg::OUTCOME_NEW;
            r.slot      = SLOT_W'(slots_in_use);
            r.span_low  = v;
            r.span_high = v;
            r.hits      = ict_pkg::VALUE_W'(1);
            slots_in_use = slots_in_use + 1'b1;
         end else begin
            r.outcome = ict_pkg::OUTCOME_DROPPED;
         end
      end
      r.used_slots = slots_in_use;
      return r;
   endfunction

   function automatic script_row_type item_row(input int unsigned v);
      script_row_type r;
      r      = '0;
      r.kind = ROW_ITEM;
      r.data = v;
      return r;
   endfunction

   function automatic script_row_type known_row(input int unsigned v,
                                                input ict_pkg::outcome_type outcome,
                                                input int unsigned slot, input int unsigned lo,
                                                input int unsigned hi, input int unsigned hits,
                                                input int unsigned used);
      script_row_type r;
      r                  = item_row(v);
      r.typed            = 1'b1;
      r.known.outcome    = outcome;
      r.known.slot       = SLOT_W'(slot);
      r.known.span_low   = ict_pkg::VALUE_W'(lo);
      r.known.span_high  = ict_pkg::VALUE_W'(hi);
      r.known.hits       = ict_pkg::VALUE_W'(hits);
      r.known.used_slots = USED_W'(used);
      return r;
   endfunction

   function automatic script_row_type cfg_row(input logic [ict_pkg::REG_IDX_W-1:0] idx,
                                              input logic [ict_pkg::DATA_W-1:0] value);
      script_row_type r;
      r         = '0;
      r.kind    = ROW_CFG;
      r.reg_idx = idx;
      r.data    = value;
      return r;
   endfunction

   function automatic void add_row(input script_row_type row);
      script = {script, row};
   endfunction

   task automatic offer_sample(input logic [ict_pkg::VALUE_W-1:0] v, input bit typed,
                               input cluster_result_type known);
      cluster_result_type predicted;
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_sample_value = v;
      do @(posedge clock); while (req_stall);
      predicted  = cluster_value(v);
      expected_q = {expected_q, (typed ? known : predicted)};
      sent_count++;
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input logic [ict_pkg::REG_IDX_W-1:0] idx,
                             input logic [ict_pkg::DATA_W-1:0] wdata,
                             output logic [ict_pkg::DATA_W-1:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = write;
      paddr   = ict_pkg::ADDR_W'({idx, 2'b00});
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic write_register(input logic [ict_pkg::REG_IDX_W-1:0] idx,
                                 input logic [ict_pkg::DATA_W-1:0] value);
      logic [ict_pkg::DATA_W-1:0] readback;
      int unsigned                held;
      bit                         present;
      held    = 0;
      present = 1'b1;
      csr_access(1'b1, idx, value, readback);
      case (idx)
         ict_pkg::REG_LOW_FACTOR: begin
            lo_factor_now = value[ict_pkg::FACTOR_W-1:0];
            held = lo_factor_now;
         end
         ict_pkg::REG_HIGH_FACTOR: begin
            hi_factor_now = value[ict_pkg::FACTOR_W-1:0];
            held = hi_factor_now;
         end
         ict_pkg::REG_MAX_GAP: begin
            gap_now = value[ict_pkg::VALUE_W-1:0];
            held = gap_now;
         end
         default: begin
            present = 1'b0;
         end
      endcase
      if (present) begin
         csr_access(1'b0, idx, '0, readback);
         check_field("register readback", held, readback);
      end
      write_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : output_side
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
            rsp_stall = 1'b0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin : result_checker
      cluster_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("result with no request waiting: outcome %0d, slot %0d",
                      rsp_outcome, rsp_slot);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("outcome", want.outcome, rsp_outcome);
               check_field("slot", want.slot, rsp_slot);
               check_field("span_low", want.span_low, rsp_span_low);
               check_field("span_high", want.span_high, rsp_span_high);
               check_field("hits", want.hits, rsp_hits);
               check_field("used_slots", want.used_slots, rsp_used_slots);
               case (want.outcome)
                  ict_pkg::OUTCOME_COUNTED: counted_seen++;
                  ict_pkg::OUTCOME_NEW:     new_seen++;
                  default:                  dropped_seen++;
               endcase
               if (rsp_hits > peak_hits) peak_hits = rsp_hits;
            end
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_interval_cluster_table: errors");
      $finish;
   end

   initial begin : stimulus
      int                         pick;
      int                         lo_end;
      int                         hi_end;
      int                         reach;
      int                         candidate;
      int                         top_value;
      logic [ict_pkg::DATA_W-1:0] lf_pick;
      logic [ict_pkg::DATA_W-1:0] hf_pick;
      logic [ict_pkg::DATA_W-1:0] gap_pick;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      idling           = 1'b1;
      long_hold        = 1'b0;
      lo_factor_now    = ict_pkg::LOW_FACTOR_RESET;
      hi_factor_now    = ict_pkg::HIGH_FACTOR_RESET;
      gap_now          = ict_pkg::MAX_GAP_RESET;
      slots_in_use     = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         span_lo_copy[k]   = '0;
         span_hi_copy[k]   = '0;
         hit_count_copy[k] = '0;
      end

      // Opening script: reset settings first, then the register extremes.
      add_row(known_row(0, ict_pkg::OUTCOME_NEW, 0, 0, 0, 1, 1));
      add_row(known_row(VALUE_MAX, ict_pkg::OUTCOME_NEW, 1, VALUE_MAX, VALUE_MAX, 1, 2));
      add_row(known_row(VALUE_MAX, ict_pkg::OUTCOME_COUNTED, 1, VALUE_MAX, VALUE_MAX, 2, 2));
      add_row(item_row(1000));
      add_row(item_row(1050));
      add_row(item_row(1020));
      add_row(item_row(950));
      add_row(item_row(1060));
      add_row(item_row(950));
      add_row(cfg_row(ict_pkg::REG_MAX_GAP, 32'd0));
      add_row(item_row(1061));
      add_row(item_row(1060));
      add_row(cfg_row(ict_pkg::REG_LOW_FACTOR, 32'd0));
      add_row(cfg_row(ict_pkg::REG_HIGH_FACTOR, 32'd511));
      add_row(cfg_row(ict_pkg::REG_MAX_GAP, 32'hFFFF_FFFF));
      add_row(item_row(2000));
      add_row(item_row(1));
      add_row(cfg_row(ict_pkg::REG_LOW_FACTOR, 32'hFFFF_FFFF));
      add_row(cfg_row(ict_pkg::REG_HIGH_FACTOR, 32'd0));
      add_row(cfg_row(REG_UNUSED, 32'hFFFF_FFFF));
      add_row(item_row(0));
      add_row(item_row(VALUE_MAX));
      add_row(cfg_row(ict_pkg::REG_LOW_FACTOR, ict_pkg::DATA_W'(ict_pkg::LOW_FACTOR_RESET)));
      add_row(cfg_row(ict_pkg::REG_HIGH_FACTOR, ict_pkg::DATA_W'(ict_pkg::HIGH_FACTOR_RESET)));
      add_row(cfg_row(ict_pkg::REG_MAX_GAP, ict_pkg::DATA_W'(ict_pkg::MAX_GAP_RESET)));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_CFG) begin
            wait_for_idle();
            write_register(script[i].reg_idx, script[i].data);
         end else begin
            offer_sample(script[i].data[ict_pkg::VALUE_W-1:0], script[i].typed,
                         script[i].known);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_idle();
         if ($urandom_range(0, 9) < 7) begin
            lf_pick  = $urandom_range(192, 255);
            hf_pick  = $urandom_range(257, 340);
            gap_pick = $urandom_range(0, 300);
         end else begin
            lf_pick  = $urandom;
            hf_pick  = $urandom;
            gap_pick = $urandom;
         end
         write_register(ict_pkg::REG_LOW_FACTOR, lf_pick);
         write_register(ict_pkg::REG_HIGH_FACTOR, hf_pick);
         write_register(ict_pkg::REG_MAX_GAP, gap_pick);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (phase == 1 && n == 20) long_hold = 1'b1;
            if (slots_in_use != 0 && $urandom_range(0, 9) < 8) begin
               pick   = $urandom_range(0, int'(slots_in_use) - 1);
               lo_end = span_lo_copy[pick];
               hi_end = span_hi_copy[pick];
               reach  = $urandom_range(0, 120);
               case ($urandom_range(0, 2))
                  0:       candidate = lo_end - reach;
                  1:       candidate = hi_end + reach;
                  default: candidate = lo_end + int'($urandom_range(0, hi_end - lo_end));
               endcase
               if (candidate < 0) candidate = 0;
               if (candidate > VALUE_MAX) candidate = VALUE_MAX;
            end else begin
               candidate = $urandom_range(0, VALUE_MAX);
            end
            offer_sample(ict_pkg::VALUE_W'(candidate), 1'b0, '0);
         end
      end

      // Closing phase, no idling: repeat one value, then fill the table.
      wait_for_idle();
      idling = 1'b0;
      write_register(ict_pkg::REG_LOW_FACTOR, ict_pkg::DATA_W'(ict_pkg::LOW_FACTOR_RESET));
      write_register(ict_pkg::REG_HIGH_FACTOR, ict_pkg::DATA_W'(ict_pkg::HIGH_FACTOR_RESET));
      write_register(ict_pkg::REG_MAX_GAP, ict_pkg::DATA_W'(ict_pkg::MAX_GAP_RESET));
      top_value = 0;
      for (int k = 0; k < int'(slots_in_use); k++) begin
         if (span_hi_copy[k] > top_value) top_value = span_hi_copy[k];
      end
      repeat (REPEAT_REQUESTS) offer_sample(ict_pkg::VALUE_W'(top_value), 1'b0, '0);
      wait_for_idle();
      write_register(ict_pkg::REG_LOW_FACTOR, 32'd511);
      write_register(ict_pkg::REG_HIGH_FACTOR, 32'd0);
      repeat (FILL_REQUESTS) begin
         offer_sample(ict_pkg::VALUE_W'($urandom_range(0, VALUE_MAX)), 1'b0, '0);
      end
      wait_for_idle();

      $display("Sent %0d requests and made %0d register writes in %0d cycles.",
               sent_count, write_count, cycle_count);
      $display("Results: %0d counted, %0d new entries, %0d dropped; peak count %0d.",
               counted_seen, new_seen, dropped_seen, peak_hits);
      if (error_count == 0) begin
         $display("tb_interval_cluster_table: clean");
      end else begin
         $display("tb_interval_cluster_table: errors");
      end
      $finish;
   end

endmodule
